/* rtl/cdvh_pkg.sv */
package cdvh_pkg;

    // default build parameters
    localparam int DefTableDepth = 16;
    localparam int DefIndexBits  = 32;

    // field widths fixed by the interface
    localparam int ValueW = 64;
    localparam int IdxW   = 32;
    localparam int CountW = 32;
    localparam int CfgW   = 5;
    localparam int ClassW = 2;

    localparam logic [CfgW-1:0] MaxDistinctReset = CfgW'(16);

    // classification codes
    localparam logic [ClassW-1:0] ClsNoSamples = 2'd0;
    localparam logic [ClassW-1:0] ClsTruncated = 2'd1;
    localparam logic [ClassW-1:0] ClsStatic    = 2'd2;
    localparam logic [ClassW-1:0] ClsDiscrete  = 2'd3;

    // one table entry as held in a cell
    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [CountW-1:0]        count;
        logic [IdxW-1:0]          first;
        logic [IdxW-1:0]          last;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [IdxW-1:0]          idx;
        logic                     take;
        logic                     insert;
        logic                     drain;
    } t_cell_ctrl;

endpackage

/* rtl/cdvh_cell.sv */
module cdvh_cell (
    input  logic                i_clk,
    input  cdvh_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  cdvh_pkg::t_entry    i_prev,
    input  logic                i_prev_ins,
    input  cdvh_pkg::t_entry    i_next,
    output cdvh_pkg::t_entry    o_entry,
    output logic                o_ins,
    output logic                o_hit
);
    import cdvh_pkg::*;

    t_entry r_e;
    t_entry n_e;

    // compare the broadcast sample against the held value
    assign o_hit = i_occ && (r_e.value == i_ctrl.value);
    assign o_ins = !i_occ || ($signed(i_ctrl.value) < $signed(r_e.value));

    // drain left, shift right on insert, load new value, or update on a hit
    always_comb begin
        n_e = r_e;
        if (i_ctrl.drain) begin
            n_e = i_next;
        end else if (i_ctrl.insert && o_ins) begin
            if (i_prev_ins) begin
                n_e = i_prev;
            end else begin
                n_e.value = i_ctrl.value;
                n_e.count = CountW'(1);
                n_e.first = i_ctrl.idx;
                n_e.last  = i_ctrl.idx;
            end
        end else if (i_ctrl.take && o_hit) begin
            if (r_e.count != '1) begin
                n_e.count = r_e.count + CountW'(1);
            end
            n_e.last = i_ctrl.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry = r_e;

endmodule

/* rtl/capped_distinct_value_histogram_unit.sv */
// channel   dir   handshake               payload
// sample    in    i_valid / o_ready       i_sample_value, i_sample_valid, i_end_of_run
// result    out   o_valid / i_ready       o_entry_value .. o_last
// config    in    i_cfg_valid / o_cfg_ready  i_cfg_data (max_distinct)
//
// samples are taken one per cycle while o_ready is high; the sorted cell row matches or inserts in that cycle
// an end marker starts a drain that shifts the row toward cell 0, one result a cycle,
// so a run of n entries holds o_ready low until its n results are loaded (one result for an empty run)
// a stalled result output stalls the drain; samples resume once the last result is loaded
// i_rst_n is synchronous and clears the run state and the register; cell contents need none
module capped_distinct_value_histogram_unit #(
    parameter int TABLE_DEPTH = cdvh_pkg::DefTableDepth,
    parameter int INDEX_BITS  = cdvh_pkg::DefIndexBits
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [cdvh_pkg::ValueW-1:0]    i_sample_value,
    input  logic                                  i_sample_valid,
    input  logic                                  i_end_of_run,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cdvh_pkg::CfgW-1:0]             i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [cdvh_pkg::ValueW-1:0]    o_entry_value,
    output logic [cdvh_pkg::CountW-1:0]           o_entry_count,
    output logic [cdvh_pkg::IdxW-1:0]             o_first_index,
    output logic [cdvh_pkg::IdxW-1:0]             o_last_index,
    output logic                                  o_entry_valid,
    output logic [cdvh_pkg::CountW-1:0]           o_total_samples,
    output logic [cdvh_pkg::CfgW-1:0]             o_distinct_count,
    output logic                                  o_truncated,
    output logic [cdvh_pkg::ClassW-1:0]           o_classification,
    output logic                                  o_last
);
    import cdvh_pkg::*;

    localparam int CntW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
    localparam int UW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = ((UW > CfgW) ? UW : CfgW) + 1;

    logic [CfgW-1:0]   r_max;
    logic [UW-1:0]     r_used, n_used;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_trunc, n_trunc;
    logic [UW-1:0]     r_left;
    logic [CountW-1:0] r_sum_total;
    logic [UW-1:0]     r_sum_used;
    logic              r_sum_trunc;
    logic [ClassW-1:0] r_sum_cls;

    logic              r_out_valid;
    t_entry            r_out_entry;
    logic              r_out_entry_valid;
    logic [CountW-1:0] r_out_total;
    logic [CfgW-1:0]   r_out_distinct;
    logic              r_out_trunc;
    logic [ClassW-1:0] r_out_cls;
    logic              r_out_last;

    t_cell_ctrl        w_ctrl;
    t_entry            w_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_ins;
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_occ;

    logic              w_in_xfer;
    logic              w_take;
    logic              w_full;
    logic              w_any_hit;
    logic              w_load_out;
    logic [ClassW-1:0] w_cls;

    // input side handshakes
    assign o_ready     = (r_left == '0);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_valid && o_ready;
    assign w_take      = w_in_xfer && i_sample_valid && !r_trunc;

    // table limit: smaller of the register and the row length
    assign w_full = (LW'(r_used) >= LW'(r_max)) || (r_used >= UW'(TABLE_DEPTH));
    assign w_any_hit = |w_hit;

    // output register loads during a drain when empty or taken
    assign w_load_out = (r_left != '0) && (!r_out_valid || i_ready);

    always_comb begin
        w_ctrl.value  = i_sample_value;
        w_ctrl.idx    = IdxW'(r_cnt);
        w_ctrl.take   = w_take;
        w_ctrl.insert = w_take && !w_any_hit && !w_full;
        w_ctrl.drain  = w_load_out;
    end

    // row of cells, kept in ascending order
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_occ[g] = (r_used > UW'(g));
        if (g == 0) begin : g_head
            cdvh_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_occ      (w_occ[g]),
                .i_prev     ('0),
                .i_prev_ins (1'b0),
                .i_next     ((TABLE_DEPTH > 1) ? w_entry[(TABLE_DEPTH > 1) ? 1 : 0] : '0),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g]),
                .o_hit      (w_hit[g])
            );
        end else if (g == TABLE_DEPTH - 1) begin : g_tail
            cdvh_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_occ      (w_occ[g]),
                .i_prev     (w_entry[g-1]),
                .i_prev_ins (w_ins[g-1]),
                .i_next     ('0),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g]),
                .o_hit      (w_hit[g])
            );
        end else begin : g_mid
            cdvh_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_occ      (w_occ[g]),
                .i_prev     (w_entry[g-1]),
                .i_prev_ins (w_ins[g-1]),
                .i_next     (w_entry[g+1]),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g]),
                .o_hit      (w_hit[g])
            );
        end
    end

    // run state after this transfer's sample
    always_comb begin
        n_cnt   = r_cnt;
        n_used  = r_used;
        n_trunc = r_trunc;
        if (w_in_xfer && i_sample_valid && (r_cnt != '1)) begin
            n_cnt = r_cnt + CntW'(1);
        end
        if (w_ctrl.insert) begin
            n_used = r_used + UW'(1);
        end
        if (w_take && !w_any_hit && w_full) begin
            n_trunc = 1'b1;
        end
    end

    // run classification
    always_comb begin
        if (n_cnt == '0) begin
            w_cls = ClsNoSamples;
        end else if (n_trunc) begin
            w_cls = ClsTruncated;
        end else if (n_used == UW'(1)) begin
            w_cls = ClsStatic;
        end else begin
            w_cls = ClsDiscrete;
        end
    end

    // run state, end of run snapshot and drain counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MaxDistinctReset;
            r_used  <= '0;
            r_cnt   <= '0;
            r_trunc <= 1'b0;
            r_left  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (w_in_xfer && i_end_of_run) begin
                r_used  <= '0;
                r_cnt   <= '0;
                r_trunc <= 1'b0;
                r_left  <= (n_used == '0) ? UW'(1) : n_used;
            end else begin
                r_used  <= n_used;
                r_cnt   <= n_cnt;
                r_trunc <= n_trunc;
                if (w_load_out) begin
                    r_left <= r_left - UW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && i_end_of_run) begin
            r_sum_total <= CountW'(n_cnt);
            r_sum_used  <= n_used;
            r_sum_trunc <= n_trunc;
            r_sum_cls   <= w_cls;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_entry       <= (r_sum_used != '0) ? w_entry[0] : '0;
            r_out_entry_valid <= (r_sum_used != '0);
            r_out_total       <= r_sum_total;
            r_out_distinct    <= CfgW'(r_sum_used);
            r_out_trunc       <= r_sum_trunc;
            r_out_cls         <= r_sum_cls;
            r_out_last        <= (r_left == UW'(1));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_entry_value    = r_out_entry.value;
    assign o_entry_count    = r_out_entry.count;
    assign o_first_index    = r_out_entry.first;
    assign o_last_index     = r_out_entry.last;
    assign o_entry_valid    = r_out_entry_valid;
    assign o_total_samples  = r_out_total;
    assign o_distinct_count = r_out_distinct;
    assign o_truncated      = r_out_trunc;
    assign o_classification = r_out_cls;
    assign o_last           = r_out_last;

    // a value sits in at most one cell
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("sample value matched more than one cell");

    // fill never passes the row length
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_DEPTH))
        else $error("used entries beyond row length");

    // the final result of a run is loaded only when the drain is done
    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && (r_left == UW'(1))) |=> (r_out_last && (r_left == '0)))
        else $error("final result shown with entries left to drain");

    // an end marker clears the run and starts a drain
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_end_of_run) |=> (r_used == '0 && r_cnt == '0 && r_left != '0))
        else $error("run state not cleared at end of run");

endmodule
